// File: design/tsfq_pkg.sv
// shared constants, codes and control types of the timestamp sorting frame queue
`default_nettype none

package tsfq_pkg;

  localparam int DEPTH        = 32;
  localparam int PTR_W        = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int PAYLOAD_BITS = 32;
  localparam int PAY_W        = 32;
  localparam int STAMP_W      = 64;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_PEEK  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_t;

endpackage

`default_nettype wire

// File: design/tsfq_if.sv
// valid/ready channel interfaces for queue commands and results
`default_nettype none

interface tsfq_cmd_if import tsfq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [PAY_W-1:0]   payload;
  logic [STAMP_W-1:0] stamp;

  modport source (output valid, output cmd, output payload, output stamp, input ready);
  modport sink   (input valid, input cmd, input payload, input stamp, output ready);
endinterface

interface tsfq_res_if import tsfq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PAY_W-1:0]    front_payload;
  logic [STAMP_W-1:0]  front_stamp;
  logic [PAY_W-1:0]    back_payload;
  logic [STAMP_W-1:0]  back_stamp;
  logic [CNT_W-1:0]    entry_count;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output front_payload, output front_stamp,
                  output back_payload, output back_stamp, output entry_count,
                  output status, input ready);
  modport sink   (input valid, input front_payload, input front_stamp,
                  input back_payload, input back_stamp, input entry_count,
                  input status, output ready);
endinterface

`default_nettype wire

// File: design/tsfq_ctrl.sv
// command sequencer: accept, execute, ring read, result handoff
`default_nettype none

module tsfq_ctrl import tsfq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  output logic  rsp_valid,
  input  logic  rsp_ready,
  output ctrl_t ctrl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_OUT
  } state_t;

  state_t state;

  always_comb begin
    ctrl.load = req_valid && req_ready;
    ctrl.exec = (state == S_EXEC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req_ready <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state     <= S_EXEC;
            req_ready <= 1'b0;
          end
        end
        S_EXEC: begin
          state <= S_READ;
        end
        S_READ: begin
          state     <= S_OUT;
          rsp_valid <= 1'b1;
        end
        S_OUT: begin
          if (rsp_ready) begin
            state     <= S_IDLE;
            rsp_valid <= 1'b0;
            req_ready <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/tsfq_datapath.sv
// payload ring memory, sorted timestamp cells, pointers and result fields
`default_nettype none

module tsfq_datapath import tsfq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  ctrl_t               ctrl,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [PAY_W-1:0]    payload,
  input  logic [STAMP_W-1:0]  stamp,
  output logic [PAY_W-1:0]    front_payload,
  output logic [STAMP_W-1:0]  front_stamp,
  output logic [PAY_W-1:0]    back_payload,
  output logic [STAMP_W-1:0]  back_stamp,
  output logic [CNT_W-1:0]    entry_count,
  output logic [STATUS_W-1:0] status
);

  // captured command
  cmd_t                    cmd_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [STAMP_W-1:0]      stamp_q;

  // queue state
  logic [PAYLOAD_BITS-1:0] ring [DEPTH];
  logic [STAMP_W-1:0]      cells [DEPTH];
  logic [PTR_W-1:0]        head;
  logic [CNT_W-1:0]        occ;
  logic [PAYLOAD_BITS-1:0] back_pay;
  logic [STAMP_W-1:0]      back_stp;
  logic [PAYLOAD_BITS-1:0] rd_data;
  status_t                 status_q;

  logic             empty;
  logic             full;
  logic             do_push;
  logic             do_pop;
  logic [PTR_W-1:0] tail;
  logic [DEPTH-1:0] gt;

  always_comb begin
    empty   = (occ == '0);
    full    = (occ == CNT_W'(DEPTH));
    do_push = ctrl.exec && (cmd_q == CMD_PUSH) && !full;
    do_pop  = ctrl.exec && (cmd_q == CMD_POP) && !empty;
    // ring wraps by power-of-two depth
    tail    = head + occ[PTR_W-1:0];
    // cell moves up when empty or holding a strictly larger stamp
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = (CNT_W'(i) >= occ) || ($signed(stamp_q) < $signed(cells[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q   <= cmd_t'(cmd);
      pay_q   <= payload[PAYLOAD_BITS-1:0];
      stamp_q <= stamp;
    end
    if (do_push) begin
      ring[tail] <= pay_q;
    end
    rd_data <= ring[head];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (gt[i]) begin
          if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
            cells[i] <= cells[(i > 0) ? i - 1 : 0];
          end else begin
            cells[i] <= stamp_q;
          end
        end
      end
    end else if (do_pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        cells[i] <= cells[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      back_pay <= pay_q;
      if (empty || !($signed(stamp_q) < $signed(back_stp))) begin
        back_stp <= stamp_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      occ      <= '0;
      status_q <= ST_OK;
    end else if (ctrl.exec) begin
      unique case (cmd_q)
        CMD_PUSH: begin
          if (full) begin
            status_q <= ST_FULL;
          end else begin
            status_q <= ST_OK;
            occ      <= occ + 1'b1;
          end
        end
        CMD_POP: begin
          if (empty) begin
            status_q <= ST_EMPTY;
          end else begin
            status_q <= ST_OK;
            occ      <= occ - 1'b1;
            head     <= (occ == CNT_W'(1)) ? '0 : head + 1'b1;
          end
        end
        CMD_CLEAR: begin
          status_q <= ST_OK;
          head     <= '0;
          occ      <= '0;
        end
        CMD_PEEK: begin
          status_q <= empty ? ST_EMPTY : ST_OK;
        end
        default: begin
          status_q <= ST_OK;
        end
      endcase
    end
  end

  always_comb begin
    if (empty) begin
      front_payload = '0;
      front_stamp   = '0;
      back_payload  = '0;
      back_stamp    = '0;
    end else begin
      front_payload = PAY_W'(rd_data);
      front_stamp   = cells[0];
      back_payload  = PAY_W'(back_pay);
      back_stamp    = back_stp;
    end
    entry_count = occ;
    status      = status_q;
  end

endmodule

`default_nettype wire

// File: design/timestamp_sorting_frame_queue_top.sv
// top level of the timestamp sorting frame queue
// usage:
//   request channel carries one command item: cmd (push, pop, clear, peek),
//   a payload handle and a signed 64-bit timestamp used by push only
//   response channel returns exactly one result item per command: front and
//   back payloads (arrival order), smallest and largest stored timestamps,
//   entry count and status (ok, empty on pop/peek, full on dropped push)
// timing:
//   one command at a time; after the accepting edge the sequencer executes
//   the command, reads the ring memory at the new head, then sets result valid
//   a new command is accepted only after the previous result is taken, as
//   set by the sequencer walking through its four states
// sorting:
//   a row of compare-and-shift cells inserts a pushed timestamp in parallel;
//   a pop shifts the whole row down by one
// reset:
//   synchronous, clears head pointer, count and sequencer; stored payloads
//   and stamps are not cleared and are never read unless occupied
// stall:
//   a held response stays stable and no new command is accepted
`default_nettype none

module timestamp_sorting_frame_queue_top import tsfq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tsfq_cmd_if.sink   request,
  tsfq_res_if.source response
);

  ctrl_t ctrl;

  // sequencer owns both handshakes
  tsfq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .rsp_valid (response.valid),
    .rsp_ready (response.ready),
    .ctrl      (ctrl)
  );

  // storage and result fields
  tsfq_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .cmd           (request.cmd),
    .payload       (request.payload),
    .stamp         (request.stamp),
    .front_payload (response.front_payload),
    .front_stamp   (response.front_stamp),
    .back_payload  (response.back_payload),
    .back_stamp    (response.back_stamp),
    .entry_count   (response.entry_count),
    .status        (response.status)
  );

endmodule

`default_nettype wire
